// ===== rtl/lsolve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsolve_pkg: shared types and constants for the 3x3 linear solver
// Fixed widths of the datapath and one step of the pipelined divider.
// ----------------------------------------------------------------------------
package lsolve_pkg;

    localparam int IN_W     = 16;               // Q8.8 inputs
    localparam int OUT_W    = 32;               // Q16.16 results
    localparam int OUT_FRAC = OUT_W / 2;
    localparam int PROD1_W  = 2 * IN_W;         // a * a
    localparam int COF_W    = PROD1_W + 1;      // difference of two products
    localparam int PROD2_W  = IN_W + COF_W;     // a * cofactor, cofactor * b
    localparam int SUM_W    = PROD2_W + 2;      // sum of three such products
    localparam int MAG_W    = SUM_W - 1;        // magnitude of a sum

    // Quotient bits resolved per divider stage.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = OUT_W / DIV_BITS;

    typedef logic signed [IN_W-1:0]    in_t;
    typedef logic signed [PROD1_W-1:0] prod1_t;
    typedef logic signed [COF_W-1:0]   cof_t;
    typedef logic signed [PROD2_W-1:0] prod2_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [OUT_W-1:0]          word_t;

    // One division lane: partial remainder, numerator bits still to shift
    // in, and the quotient built so far.
    typedef struct packed {
        mag_t  rem;
        word_t low;
        word_t quo;
    } lane_t;

    typedef struct packed {
        lane_t [2:0] lane;
        mag_t        den;
        logic [2:0]  neg;
        logic [2:0]  pre_ovf;
        logic        singular;
    } div_t;

    // Restoring division, DIV_BITS quotient bits.
    function automatic lane_t div_step(lane_t l, mag_t den);
        lane_t        r;
        logic [MAG_W:0] t;
        r = l;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r.rem, r.low[OUT_W-1]};
            r.low = {r.low[OUT_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t = t - {1'b0, den};
                r.quo = {r.quo[OUT_W-2:0], 1'b1};
            end else begin
                r.quo = {r.quo[OUT_W-2:0], 1'b0};
            end
            r.rem = t[MAG_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/linear_solve_3x3.sv =====
`timescale 1ns / 1ps
// A beat passes stages 1 to 4, the divider and the output register.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while a result waits on m_ready, so a stall loses no beat.
// The divider resolves two quotient bits in each of its 16 stages.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// linear_solve_3x3: pipelined 3x3 linear system solver
// Solves A x = b by the adjugate method, x = adj(A) b / det(A), with
// Q8.8 inputs and saturated Q16.16 results plus singular and overflow flags.
// ----------------------------------------------------------------------------
module linear_solve_3x3 import lsolve_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_a00,
    input  logic [15:0] s_a01,
    input  logic [15:0] s_a02,
    input  logic [15:0] s_a10,
    input  logic [15:0] s_a11,
    input  logic [15:0] s_a12,
    input  logic [15:0] s_a20,
    input  logic [15:0] s_a21,
    input  logic [15:0] s_a22,
    input  logic [15:0] s_rhs0,
    input  logic [15:0] s_rhs1,
    input  logic [15:0] s_rhs2,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sol0,
    output logic [31:0] m_sol1,
    output logic [31:0] m_sol2,
    output logic        m_singular,
    output logic        m_overflow
);

    // All stages move together whenever the output register is free or
    // is being emptied in this cycle.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    in_t a [3][3];
    in_t b [3];

    assign a[0][0] = s_a00;  assign a[0][1] = s_a01;  assign a[0][2] = s_a02;
    assign a[1][0] = s_a10;  assign a[1][1] = s_a11;  assign a[1][2] = s_a12;
    assign a[2][0] = s_a20;  assign a[2][1] = s_a21;  assign a[2][2] = s_a22;
    assign b[0] = s_rhs0;
    assign b[1] = s_rhs1;
    assign b[2] = s_rhs2;

    // ------------------------------------------------------------------
    // Stage 1: the eighteen 2x2 minor products. The cyclic index form
    // gives signed cofactors directly, no sign table needed.
    // ------------------------------------------------------------------
    logic   v1_reg;
    prod1_t pp_reg [3][3];
    prod1_t pm_reg [3][3];
    in_t    row0_1_reg [3];
    in_t    b1_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    pp_reg[r][c] <= a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3];
                    pm_reg[r][c] <= a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
                end
                row0_1_reg[r] <= a[0][r];
                b1_reg[r]     <= b[r];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cofactors.
    // ------------------------------------------------------------------
    logic v2_reg;
    cof_t cof_reg [3][3];
    in_t  row0_2_reg [3];
    in_t  b2_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    cof_reg[r][c] <= COF_W'(pp_reg[r][c]) - COF_W'(pm_reg[r][c]);
                end
                row0_2_reg[r] <= row0_1_reg[r];
                b2_reg[r]     <= b1_reg[r];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: determinant terms along row 0 and the adjugate-times-b
    // terms. Column i of the cofactor matrix is row i of the adjugate.
    // ------------------------------------------------------------------
    logic   v3_reg;
    prod2_t dp_reg [3];
    prod2_t np_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                dp_reg[i] <= row0_2_reg[i] * cof_reg[0][i];
                for (int k = 0; k < 3; k++) begin
                    np_reg[i][k] <= cof_reg[k][i] * b2_reg[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: exact determinant and numerators.
    // ------------------------------------------------------------------
    logic v4_reg;
    sum_t det_reg;
    sum_t num_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg <= SUM_W'(dp_reg[0]) + SUM_W'(dp_reg[1]) + SUM_W'(dp_reg[2]);
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= SUM_W'(np_reg[i][0]) + SUM_W'(np_reg[i][1])
                            + SUM_W'(np_reg[i][2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: sign/magnitude split and divider setup. The quotient
    // n * 2^16 / d fits in 32 bits exactly when n < d * 2^16; otherwise
    // the lane is flagged to saturate and its division is a don't care.
    // ------------------------------------------------------------------
    div_t div_next;
    mag_t det_mag;
    mag_t num_mag [3];
    mag_t num_hi  [3];

    always_comb begin
        det_mag = det_reg[SUM_W-1] ? MAG_W'(-det_reg) : MAG_W'(det_reg);
        div_next.den      = det_mag;
        div_next.singular = (det_reg == '0);
        for (int i = 0; i < 3; i++) begin
            num_mag[i] = num_reg[i][SUM_W-1] ? MAG_W'(-num_reg[i]) : MAG_W'(num_reg[i]);
            num_hi[i]  = num_mag[i] >> OUT_FRAC;
            div_next.neg[i]      = num_reg[i][SUM_W-1] ^ det_reg[SUM_W-1];
            div_next.pre_ovf[i]  = (num_hi[i] >= det_mag);
            div_next.lane[i].rem = div_next.pre_ovf[i] ? '0 : num_hi[i];
            div_next.lane[i].low = {num_mag[i][OUT_FRAC-1:0], {(OUT_W-OUT_FRAC){1'b0}}};
            div_next.lane[i].quo = '0;
        end
    end

    // ------------------------------------------------------------------
    // Divider pipeline: stage 0 holds the setup, each later stage adds
    // DIV_BITS quotient bits to all three lanes.
    // ------------------------------------------------------------------
    logic dv_reg  [DIV_STAGES+1];
    div_t div_reg [DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_reg[0] <= div_next;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                div_reg[s].den      <= div_reg[s-1].den;
                div_reg[s].neg      <= div_reg[s-1].neg;
                div_reg[s].pre_ovf  <= div_reg[s-1].pre_ovf;
                div_reg[s].singular <= div_reg[s-1].singular;
                for (int i = 0; i < 3; i++) begin
                    div_reg[s].lane[i] <= div_step(div_reg[s-1].lane[i], div_reg[s-1].den);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: saturate to the signed range, apply the sign, and
    // force zeros for a singular matrix.
    // ------------------------------------------------------------------
    div_t  fin;
    word_t lim  [3];
    word_t magv [3];
    word_t sol_next [3];
    logic  [2:0] sat;
    logic  ovf_next;

    always_comb begin
        fin = div_reg[DIV_STAGES];
        for (int i = 0; i < 3; i++) begin
            lim[i]  = fin.neg[i] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            sat[i]  = fin.pre_ovf[i] || (fin.lane[i].quo > lim[i]);
            magv[i] = sat[i] ? lim[i] : fin.lane[i].quo;
            sol_next[i] = fin.singular ? '0 : (fin.neg[i] ? -magv[i] : magv[i]);
        end
        ovf_next = !fin.singular && (sat != '0);
    end

    logic  out_valid_reg;
    word_t sol_reg [3];
    logic  singular_reg;
    logic  overflow_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sol_reg[i] <= sol_next[i];
            end
            singular_reg <= fin.singular;
            overflow_reg <= ovf_next;
        end
    end

    // Valid bits travel beside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s <= DIV_STAGES; s++) begin
                dv_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                dv_reg[s] <= dv_reg[s-1];
            end
            out_valid_reg <= dv_reg[DIV_STAGES];
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_sol0     = sol_reg[0];
    assign m_sol1     = sol_reg[1];
    assign m_sol2     = sol_reg[2];
    assign m_singular = singular_reg;
    assign m_overflow = overflow_reg;

endmodule

// ===== rtl/lsolve_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsolve_chk: port-level checks for the 3x3 linear solver
// Watches the result channel and flags inconsistent result beats.
// ----------------------------------------------------------------------------
module lsolve_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_sol0,
    input logic [31:0] m_sol1,
    input logic [31:0] m_sol2,
    input logic        m_singular,
    input logic        m_overflow
);

    // A singular beat carries zero solutions and no overflow.
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |->
            m_sol0 == 32'd0 && m_sol1 == 32'd0 && m_sol2 == 32'd0 && !m_overflow)
        else $error("singular beat with nonzero payload");

    // Overflow means at least one entry sits at a range limit.
    a_overflow_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |->
            m_sol0 == 32'h7fffffff || m_sol0 == 32'h80000000 ||
            m_sol1 == 32'h7fffffff || m_sol1 == 32'h80000000 ||
            m_sol2 == 32'h7fffffff || m_sol2 == 32'h80000000)
        else $error("overflow beat without a saturated entry");

    // A stalled result beat holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sol0) && $stable(m_sol1)
            && $stable(m_sol2) && $stable(m_singular) && $stable(m_overflow))
        else $error("result beat changed under stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind linear_solve_3x3 lsolve_chk u_lsolve_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_sol0     (m_sol0),
    .m_sol1     (m_sol1),
    .m_sol2     (m_sol2),
    .m_singular (m_singular),
    .m_overflow (m_overflow)
);
